// ===== hw/rtl/tpsu_pkg.sv =====
// Shared types and constants for the tick-driven PWM and soft 8N1 UART block.
// No dependencies.
`timescale 1ns / 1ps

package tpsu_pkg;

  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 16;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_PWM_PERIOD = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PWM_DUTY   = 1'd1;

  localparam logic [15:0] PWM_PERIOD_RST = 16'd100;
  localparam logic [15:0] PWM_DUTY_RST   = 16'd0;

  // start bit, eight data bits, stop bit
  localparam logic [3:0] TX_STOP_IDX  = 4'd9;
  localparam logic [3:0] RX_LAST_SLOT = 4'd8;

  typedef struct packed {
    logic       rx_pin;
    logic       tx_has_byte;
    logic [7:0] tx_data;
  } tick_in_t;

  typedef struct packed {
    logic       pwm_out;
    logic       tx_line;
    logic       tx_take;
    logic       rx_valid;
    logic [7:0] rx_data;
  } tick_out_t;

endpackage

// ===== hw/rtl/tick_pwm_and_soft_uart_top.sv =====
// Top level of the tick-driven PWM generator and bit-banged 8N1 transmitter/receiver.
// Depends on tpsu_pkg.
`timescale 1ns / 1ps
//
// Usage:
//   Each transfer on the in_ channel is one timer tick: the sampled rx line and
//   an optionally offered transmit byte. Every tick gives exactly one result on
//   the out_ channel: PWM level, tx line level, whether the offered byte was
//   taken, and a received byte when one completes (rx_data is zero otherwise).
//   The tick's state update and its result are written in the cycle of the
//   input transfer, and the result shows on out_ in the next.
//   Throughput is one tick per clock; the only limit is the single output
//   register. While out_stall holds a result, in_stall is raised and no tick
//   is taken; a tick is taken in the same cycle the waiting result leaves.
//   The cfg_ port writes pwm_period (index 0) and pwm_duty (index 1); write it
//   only when no tick is in flight.
//   Reset (rst_n low, synchronous) empties the output register, sets period
//   100 and duty 0, PWM low, tx line high and idle, and the receiver disarmed.
//   Bit time is TICKS_PER_BIT ticks; the receiver samples each data bit at its
//   middle after a falling edge on the rx line.

module tick_pwm_and_soft_uart_top
  import tpsu_pkg::*;
#(
  parameter int unsigned TICKS_PER_BIT = 6
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  tick_in_t              in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output tick_out_t             out_data
);

  localparam int unsigned SUB_W = $clog2(TICKS_PER_BIT);
  localparam int unsigned HALF  = TICKS_PER_BIT / 2;
  localparam logic [SUB_W-1:0] SUB_LAST    = SUB_W'(TICKS_PER_BIT - 1);
  localparam logic [SUB_W-1:0] SUB_SAMPLE  = SUB_W'(HALF);
  localparam logic [SUB_W-1:0] SUB_RX_DONE = SUB_W'(TICKS_PER_BIT - HALF);

  logic [15:0] pwm_period_r, pwm_duty_r;

  logic [15:0] pwm_counter_r, pwm_counter_nxt;
  logic        pwm_level_r, pwm_level_nxt;

  logic             tx_busy_r, tx_busy_nxt;
  logic [3:0]       tx_bit_index_r, tx_bit_index_nxt;
  logic [7:0]       tx_shift_r, tx_shift_nxt;
  logic [SUB_W-1:0] tx_phase_r, tx_phase_nxt;
  logic             tx_level_r, tx_level_nxt;

  // rx position is kept as bit slot and tick within the slot
  logic             rx_active_r, rx_active_nxt;
  logic [SUB_W-1:0] rx_sub_r, rx_sub_nxt;
  logic [3:0]       rx_slot_r, rx_slot_nxt;
  logic [7:0]       rx_shift_r, rx_shift_nxt;
  logic             rx_previous_r;

  logic      out_valid_r;
  tick_out_t out_data_r, out_data_nxt;

  logic in_fire;
  logic take, arm;
  logic [3:0] tx_idx_m1, rx_slot_m1;
  logic [15:0] pwm_inc;

  assign in_stall  = out_valid_r & out_stall;
  assign in_fire   = in_valid & ~in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    pwm_inc         = pwm_counter_r + 16'd1;
    pwm_counter_nxt = pwm_inc;
    pwm_level_nxt   = pwm_level_r;
    if (pwm_inc < pwm_period_r) begin
      if (pwm_duty_r == pwm_inc) pwm_level_nxt = 1'b0;
    end else begin
      pwm_counter_nxt = '0;
      pwm_level_nxt   = (pwm_duty_r != '0);
    end

    // transmitter
    take             = in_data.tx_has_byte & ~tx_busy_r;
    tx_busy_nxt      = tx_busy_r | take;
    tx_shift_nxt     = take ? in_data.tx_data : tx_shift_r;
    tx_bit_index_nxt = take ? 4'd0 : tx_bit_index_r;
    tx_level_nxt     = tx_level_r;
    tx_idx_m1        = tx_bit_index_nxt - 4'd1;
    if (tx_busy_nxt && tx_phase_r == '0) begin
      if (tx_bit_index_nxt == 4'd0) begin
        tx_level_nxt = 1'b0;
      end else if (tx_bit_index_nxt < TX_STOP_IDX) begin
        tx_level_nxt = tx_shift_nxt[tx_idx_m1[2:0]];
      end else begin
        tx_level_nxt = 1'b1;
        tx_busy_nxt  = 1'b0;
      end
      tx_bit_index_nxt = tx_bit_index_nxt + 4'd1;
    end
    tx_phase_nxt = (tx_phase_r == SUB_LAST) ? '0 : tx_phase_r + SUB_W'(1);

    // receiver
    arm           = ~rx_active_r & rx_previous_r & ~in_data.rx_pin;
    rx_active_nxt = rx_active_r | arm;
    rx_sub_nxt    = arm ? '0 : rx_sub_r;
    rx_slot_nxt   = arm ? 4'd0 : rx_slot_r;
    rx_shift_nxt  = arm ? 8'd0 : rx_shift_r;
    rx_slot_m1    = rx_slot_nxt - 4'd1;

    out_data_nxt.rx_valid = 1'b0;
    out_data_nxt.rx_data  = 8'd0;
    if (rx_active_nxt) begin
      // slot 0 is the start bit; slots 1..8 carry data bits 0..7
      if (rx_sub_nxt == SUB_SAMPLE && rx_slot_nxt != 4'd0) begin
        rx_shift_nxt[rx_slot_m1[2:0]] = rx_shift_nxt[rx_slot_m1[2:0]] | in_data.rx_pin;
      end
      if (rx_slot_nxt == RX_LAST_SLOT && rx_sub_nxt == SUB_RX_DONE) begin
        out_data_nxt.rx_valid = 1'b1;
        out_data_nxt.rx_data  = rx_shift_nxt;
        rx_active_nxt         = 1'b0;
        rx_sub_nxt            = '0;
        rx_slot_nxt           = 4'd0;
      end else if (rx_sub_nxt == SUB_LAST) begin
        rx_sub_nxt  = '0;
        rx_slot_nxt = rx_slot_nxt + 4'd1;
      end else begin
        rx_sub_nxt = rx_sub_nxt + SUB_W'(1);
      end
    end

    out_data_nxt.pwm_out = pwm_level_nxt;
    out_data_nxt.tx_line = tx_level_nxt;
    out_data_nxt.tx_take = take;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pwm_period_r   <= PWM_PERIOD_RST;
      pwm_duty_r     <= PWM_DUTY_RST;
      pwm_counter_r  <= '0;
      pwm_level_r    <= 1'b0;
      tx_busy_r      <= 1'b0;
      tx_bit_index_r <= '0;
      tx_shift_r     <= '0;
      tx_phase_r     <= '0;
      tx_level_r     <= 1'b1;
      rx_active_r    <= 1'b0;
      rx_sub_r       <= '0;
      rx_slot_r      <= '0;
      rx_shift_r     <= '0;
      rx_previous_r  <= 1'b1;
      out_valid_r    <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_PWM_PERIOD: pwm_period_r <= cfg_wdata;
          REG_PWM_DUTY:   pwm_duty_r   <= cfg_wdata;
          default: ;
        endcase
      end
      if (in_fire) begin
        pwm_counter_r  <= pwm_counter_nxt;
        pwm_level_r    <= pwm_level_nxt;
        tx_busy_r      <= tx_busy_nxt;
        tx_bit_index_r <= tx_bit_index_nxt;
        tx_shift_r     <= tx_shift_nxt;
        tx_phase_r     <= tx_phase_nxt;
        tx_level_r     <= tx_level_nxt;
        rx_active_r    <= rx_active_nxt;
        rx_sub_r       <= rx_sub_nxt;
        rx_slot_r      <= rx_slot_nxt;
        rx_shift_r     <= rx_shift_nxt;
        rx_previous_r  <= in_data.rx_pin;
        out_valid_r    <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) out_data_r <= out_data_nxt;
  end

  // idle transmitter takes an offered byte
  a_tx_take_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && in_data.tx_has_byte && !tx_busy_r |=> out_data_r.tx_take)
    else $error("offered byte not taken by idle transmitter");

  a_tx_no_take_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && tx_busy_r |=> !out_data_r.tx_take)
    else $error("byte taken while transmitter busy");

  a_tx_idle_high: assert property (@(posedge clk) disable iff (!rst_n)
    !tx_busy_r |-> tx_level_r)
    else $error("tx line low while transmitter idle");

  a_rx_done_reported: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && $fell(rx_active_r) |-> out_valid_r && out_data_r.rx_valid)
    else $error("receiver disarmed without reporting a byte");

endmodule
